FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the compensation block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_HOLDS(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/ptc_pkg.sv
// Package for the pressure/temperature compensation pipeline: register
// indexes, internal widths, constants and shift/saturate helpers. No dependencies.
package ptc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SENS      = 3'd0,
		REG_OFF       = 3'd1,
		REG_SENS_TEMP = 3'd2,
		REG_OFF_TEMP  = 3'd3,
		REG_REF_TEMP  = 3'd4,
		REG_TEMP_GAIN = 3'd5
	} cfg_reg_t;

	localparam int unsigned COEFF_W = 16;
	localparam int unsigned RAW_W   = 24;
	localparam int unsigned RES_W   = 32;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned STAGES  = 11;

	// Internal widths
	localparam int unsigned W_ACC  = 72; // helper argument width
	localparam int unsigned W_DT   = 25; // dT
	localparam int unsigned W_PRD  = 42; // coefficient * dT
	localparam int unsigned W_SQ   = 48; // dT^2
	localparam int unsigned W_DEV  = 19; // TEMP - 2000
	localparam int unsigned W_SO   = 36; // SENS, OFF
	localparam int unsigned W_TI   = 17; // Ti
	localparam int unsigned W_DSQ  = 34; // (TEMP-2000)^2
	localparam int unsigned W_CSQ  = 36; // (TEMP+1500)^2
	localparam int unsigned W_CORR = 40; // OFFi, SENSi
	localparam int unsigned W_S2   = 42; // OFF2, SENS2
	localparam int unsigned W_HALF = 21; // split point of SENS2
	localparam int unsigned W_LO   = 45;
	localparam int unsigned W_HI   = 46;
	localparam int unsigned W_PROD = 67;
	localparam int unsigned W_Q    = 46;
	localparam int unsigned W_DIFF = 47;
	localparam int unsigned W_TMP  = 21;

	// Temperature constants: the 20.00 C reference and offsets from it
	localparam logic signed [W_TMP-1:0] TEMP_BASE = W_TMP'(2000);
	localparam logic signed [W_DEV:0]   COLD_BIAS = (W_DEV+1)'(3500);  // TEMP + 1500
	localparam logic signed [W_DEV-1:0] DEV_VCOLD = W_DEV'(-3600);     // TEMP <= -1600

	// Signed shift right that rounds toward zero, like C division by 2^sh
	function automatic logic signed [W_ACC-1:0] shr_trunc(
		input logic signed [W_ACC-1:0] x,
		input int unsigned             sh
	);
		logic signed [W_ACC-1:0] bias;
		bias = x[W_ACC-1] ? ((W_ACC'(1) <<< sh) - W_ACC'(1)) : '0;
		return (x + bias) >>> sh;
	endfunction

	// Clamp to the 32-bit signed range
	function automatic logic signed [RES_W-1:0] sat32(input logic signed [W_ACC-1:0] v);
		logic fits;
		fits = (&v[W_ACC-1:RES_W-1]) | ~(|v[W_ACC-1:RES_W-1]);
		if (fits)
			return v[RES_W-1:0];
		else if (v[W_ACC-1])
			return {1'b1, {(RES_W-1){1'b0}}};
		else
			return {1'b0, {(RES_W-1){1'b1}}};
	endfunction

endpackage

FILE: hw/rtl/pressure_temperature_compensation.sv
// Each accepted input word passes through stages S1 to S11 to its result word.
// Throughput: one word per cycle; the eleven stages advance together and hold
// as a whole only while the output register is full and not taken.
// Reset: clears all stage valid bits and the six coefficients to zero.
// Depends on ptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pressure_temperature_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [ptc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [ptc_pkg::COEFF_W-1:0]         cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ptc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]           raw_temperature,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ptc_pkg::RES_W-1:0]    temperature_centi,
	output logic signed [ptc_pkg::RES_W-1:0]    pressure_value
);
	import ptc_pkg::*;

	// Calibration coefficients
	logic [COEFF_W-1:0] sens_coeff_q, offset_coeff_q, sens_temp_coeff_q;
	logic [COEFF_W-1:0] offset_temp_coeff_q, ref_temp_coeff_q, temp_gain_coeff_q;

	logic [STAGES-1:0] vld_q;
	logic              adv;

	// Stage registers
	logic [RAW_W-1:0]              d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [W_DT-1:0]        dt_s1;
	logic signed [W_PRD-1:0]       sdt_s2, odt_s2, tdt_s2;
	logic [W_SQ-1:0]               dt2_s2;
	logic signed [W_SO-1:0]        sens_s3, sens_s4, sens_s5;
	logic signed [W_SO-1:0]        off_s3, off_s4, off_s5;
	logic signed [W_DEV-1:0]       dev_s3;
	logic [W_TI-1:0]               ti_cold_s3, ti_warm_s3;
	logic [W_DSQ-1:0]              dev2_s4;
	logic [W_CSQ-1:0]              cold2_s4;
	logic                          cold_s4, vcold_s4;
	logic signed [W_TMP-1:0]       temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [W_TMP-1:0]       temp_s10;
	logic [W_CORR-1:0]             offi_s5, sensi_s5;
	logic signed [W_S2-1:0]        off2_s6, off2_s7, off2_s8, off2_s9;
	logic signed [W_S2-1:0]        sens2_s6;
	logic [W_LO-1:0]               lo_s7;
	logic signed [W_HI-1:0]        hi_s7;
	logic signed [W_PROD-1:0]      prod_s8;
	logic signed [W_Q-1:0]         q_s9;
	logic signed [W_DIFF-1:0]      diff_s10;
	logic signed [RES_W-1:0]       temp_s11, press_s11;

	// Stage logic
	logic signed [W_DT-1:0]        dt_c;
	logic signed [W_PRD-1:0]       sdt_c, odt_c, tdt_c;
	logic signed [2*W_DT-1:0]      sq_c;
	logic signed [W_PRD-1:0]       sdiv_c, odiv_c;
	logic [W_SQ+1:0]               dt2x3_c;
	logic signed [2*W_DEV-1:0]     dev2_c;
	logic signed [W_DEV:0]         cold_c;
	logic signed [2*W_DEV+1:0]     cold2_c;
	logic [W_TI-1:0]               ti_sel_c;
	logic [W_DSQ+1:0]              dev2x3_c;
	logic [W_DSQ+2:0]              dev2x5_c;
	logic [W_CSQ+2:0]              cold2x7_c;
	logic [W_CORR-1:0]             offi_c, sensi_c;
	logic [W_LO-1:0]               lo_c;
	logic signed [W_HI-1:0]        hi_c;

	// Whole pipeline moves unless a finished word waits at the output and is not taken
	assign adv       = !vld_q[STAGES-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[STAGES-1];
	assign temperature_centi = temp_s11;
	assign pressure_value    = press_s11;

	// Coefficient writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_coeff_q        <= '0;
			offset_coeff_q      <= '0;
			sens_temp_coeff_q   <= '0;
			offset_temp_coeff_q <= '0;
			ref_temp_coeff_q    <= '0;
			temp_gain_coeff_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SENS:      sens_coeff_q        <= cfg_data;
				REG_OFF:       offset_coeff_q      <= cfg_data;
				REG_SENS_TEMP: sens_temp_coeff_q   <= cfg_data;
				REG_OFF_TEMP:  offset_temp_coeff_q <= cfg_data;
				REG_REF_TEMP:  ref_temp_coeff_q    <= cfg_data;
				REG_TEMP_GAIN: temp_gain_coeff_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	// S1: dT = D2 - C5*2^8
	assign dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temp_coeff_q, 8'd0});

	// S2: coefficient products and dT^2
	assign sdt_c = $signed({1'b0, sens_temp_coeff_q}) * dt_s1;
	assign odt_c = $signed({1'b0, offset_temp_coeff_q}) * dt_s1;
	assign tdt_c = $signed({1'b0, temp_gain_coeff_q}) * dt_s1;
	assign sq_c  = dt_s1 * dt_s1;

	// S3: first-order SENS, OFF, TEMP deviation and both Ti candidates
	assign sdiv_c  = W_PRD'(shr_trunc(W_ACC'(sdt_s2), 8));
	assign odiv_c  = W_PRD'(shr_trunc(W_ACC'(odt_s2), 7));
	assign dt2x3_c = {1'b0, dt2_s2, 1'b0} + {2'b0, dt2_s2};

	// S4: squares for the second-order terms, compensated temperature
	assign dev2_c   = dev_s3 * dev_s3;
	assign cold_c   = $signed({dev_s3[W_DEV-1], dev_s3}) + COLD_BIAS;
	assign cold2_c  = cold_c * cold_c;
	assign ti_sel_c = dev_s3[W_DEV-1] ? ti_cold_s3 : ti_warm_s3;

	// S5: OFFi and SENSi per temperature range
	assign dev2x3_c  = {1'b0, dev2_s4, 1'b0} + {2'b0, dev2_s4};
	assign dev2x5_c  = {1'b0, dev2_s4, 2'b0} + {3'b0, dev2_s4};
	assign cold2x7_c = {cold2_s4, 3'b0} - {3'b0, cold2_s4};

	always_comb begin
		if (cold_s4) begin
			offi_c  = W_CORR'(dev2x3_c[W_DSQ+1:1]) + (vcold_s4 ? W_CORR'(cold2x7_c) : '0);
			sensi_c = W_CORR'(dev2x5_c[W_DSQ+2:3]) + (vcold_s4 ? W_CORR'({cold2_s4, 2'b0}) : '0);
		end else begin
			offi_c  = W_CORR'(dev2_s4[W_DSQ-1:4]);
			sensi_c = '0;
		end
	end

	// S7: D1 * SENS2 as two partial products
	assign lo_c = d1_s6 * sens2_s6[W_HALF-1:0];
	assign hi_c = $signed({1'b0, d1_s6}) * $signed(sens2_s6[W_S2-1:W_HALF]);

	// Advance payload; no reset needed
	always_ff @(posedge clk) begin
		if (adv) begin
			// S1
			d1_s1 <= raw_pressure;
			dt_s1 <= dt_c;
			// S2
			d1_s2  <= d1_s1;
			sdt_s2 <= sdt_c;
			odt_s2 <= odt_c;
			tdt_s2 <= tdt_c;
			dt2_s2 <= sq_c[W_SQ-1:0];
			// S3
			d1_s3      <= d1_s2;
			sens_s3    <= W_SO'(sdiv_c) + $signed({5'd0, sens_coeff_q, 15'd0});
			off_s3     <= W_SO'(odiv_c) + $signed({4'd0, offset_coeff_q, 16'd0});
			dev_s3     <= W_DEV'(shr_trunc(W_ACC'(tdt_s2), 23));
			ti_cold_s3 <= dt2x3_c[W_SQ+1:33];
			ti_warm_s3 <= W_TI'(dt2_s2[W_SQ-1:36]);
			// S4; the temperature always fits the 32-bit range
			d1_s4    <= d1_s3;
			sens_s4  <= sens_s3;
			off_s4   <= off_s3;
			dev2_s4  <= dev2_c[W_DSQ-1:0];
			cold2_s4 <= cold2_c[W_CSQ-1:0];
			cold_s4  <= dev_s3[W_DEV-1];
			vcold_s4 <= (dev_s3 <= DEV_VCOLD);
			temp_s4  <= W_TMP'(dev_s3) + TEMP_BASE - $signed({4'd0, ti_sel_c});
			// S5
			d1_s5    <= d1_s4;
			sens_s5  <= sens_s4;
			off_s5   <= off_s4;
			offi_s5  <= offi_c;
			sensi_s5 <= sensi_c;
			temp_s5  <= temp_s4;
			// S6: second-order OFF2 and SENS2
			d1_s6    <= d1_s5;
			off2_s6  <= W_S2'(off_s5) - $signed({2'b0, offi_s5});
			sens2_s6 <= W_S2'(sens_s5) - $signed({2'b0, sensi_s5});
			temp_s6  <= temp_s5;
			// S7
			lo_s7   <= lo_c;
			hi_s7   <= hi_c;
			off2_s7 <= off2_s6;
			temp_s7 <= temp_s6;
			// S8: recombine the partial products
			prod_s8 <= (W_PROD'(hi_s7) <<< W_HALF) + $signed({22'd0, lo_s7});
			off2_s8 <= off2_s7;
			temp_s8 <= temp_s7;
			// S9: divide by 2^21
			q_s9    <= W_Q'(shr_trunc(W_ACC'(prod_s8), 21));
			off2_s9 <= off2_s8;
			temp_s9 <= temp_s8;
			// S10: subtract OFF2
			diff_s10 <= W_DIFF'(q_s9) - W_DIFF'(off2_s9);
			temp_s10 <= temp_s9;
			// S11: divide by 2^13, clamp, hold for the output
			press_s11 <= sat32(shr_trunc(W_ACC'(diff_s10), 13));
			temp_s11  <= RES_W'(temp_s10);
		end
	end

	// Checks
	`ASSERT_NEXT(a_stall_holds_valids, clk, arst_n, !adv, $stable(vld_q))
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, vld_q[0])
	`ASSERT_HOLDS(a_vcold_is_cold, clk, arst_n, vld_q[3] && vcold_s4, cold_s4)
	`ASSERT_NEXT(a_warm_no_sensi, clk, arst_n, adv && vld_q[3] && !cold_s4, sensi_s5 == '0)

endmodule

FILE: dv/pressure_temperature_compensation_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the pressure/temperature compensation pipeline: scoreboard with
// its own 64-bit compensation math, valid/ready drivers with random gaps and long stalls.
// Depends on ptc_pkg and the pressure_temperature_compensation RTL.
module pressure_temperature_compensation_tb;
	import ptc_pkg::*;

	localparam int NUM_COEFFS   = 6;
	localparam int PIPE_DEPTH   = STAGES;
	localparam int LONG_HOLD    = 150;
	localparam int HOLD_POINT_A = 120;
	localparam int HOLD_POINT_B = 900;
	localparam int DRAIN_LIMIT  = 20000;
	localparam longint WATCHDOG_NS = 3_000_000;

	localparam logic [RAW_W-1:0] RAW_MAX = '1;
	// Indexes past the last coefficient; writes there must be dropped
	localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;

	// Datasheet scaling constants
	localparam longint TEMP_REF    = 2000;
	localparam longint COLD_REF    = 1500;
	localparam longint SCALE_TEMP  = 64'sd8388608;
	localparam longint SCALE_TLOW  = 64'sd8589934592;
	localparam longint SCALE_THIGH = 64'sd137438953472;
	localparam longint SCALE_PRESS = 64'sd2097152;
	localparam longint SCALE_OUT   = 64'sd8192;
	localparam longint SAT_HI      = 64'sd2147483647;
	localparam longint SAT_LO      = -64'sd2147483648;

	// Temperatures hit exactly under the directed coefficients (C5 = C6 = 2^15)
	localparam int DIRECTED_TEMPS [12] = '{2000, 1999, 2099, 2100, 0, -99,
		-1500, -1599, -1600, -1601, -30768, 34767};

	typedef struct {
		logic [RAW_W-1:0]        d1;
		logic [RAW_W-1:0]        d2;
		logic signed [RES_W-1:0] temp_centi;
		logic signed [RES_W-1:0] pressure;
	} reading_t;

	class compensation_checker;
		logic [COEFF_W-1:0] coeff [NUM_COEFFS];
		reading_t pending_readings [$];
		int failures;

		function new();
			foreach (coeff[i]) coeff[i] = '0;
			failures = 0;
		endfunction

		task report(string msg);
			failures++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function void store_coeff(logic [IDX_W-1:0] idx, logic [COEFF_W-1:0] val);
			if (idx < NUM_COEFFS)
				coeff[idx] = val;
		endfunction

		function logic signed [RES_W-1:0] clamp32(longint v);
			if (v > SAT_HI)
				return SAT_HI[RES_W-1:0];
			if (v < SAT_LO)
				return SAT_LO[RES_W-1:0];
			return v[RES_W-1:0];
		endfunction

		// First-order terms, then the low / very low / high temperature correction
		function reading_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
			longint dt, sens, off, temp, dev, ti, offi, sensi, cold, press;
			reading_t r;
			dt = longint'(d2) - longint'(coeff[REG_REF_TEMP]) * 256;
			sens = longint'(coeff[REG_SENS]) * 32768
				+ (longint'(coeff[REG_SENS_TEMP]) * dt) / 256;
			off = longint'(coeff[REG_OFF]) * 65536
				+ (longint'(coeff[REG_OFF_TEMP]) * dt) / 128;
			temp = TEMP_REF + (dt * longint'(coeff[REG_TEMP_GAIN])) / SCALE_TEMP;
			dev = temp - TEMP_REF;
			if (temp / 100 < 20) begin
				ti = (3 * dt * dt) / SCALE_TLOW;
				offi = (3 * dev * dev) / 2;
				sensi = (5 * dev * dev) / 8;
				if (temp / 100 < -15) begin
					cold = temp + COLD_REF;
					offi += 7 * cold * cold;
					sensi += 4 * cold * cold;
				end
			end else begin
				ti = (2 * dt * dt) / SCALE_THIGH;
				offi = (dev * dev) / 16;
				sensi = 0;
			end
			press = ((longint'(d1) * (sens - sensi)) / SCALE_PRESS - (off - offi)) / SCALE_OUT;
			r.d1 = d1;
			r.d2 = d2;
			r.temp_centi = clamp32(temp - ti);
			r.pressure = clamp32(press);
			return r;
		endfunction

		function void note_word(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
			pending_readings.push_back(compensate(d1, d2));
		endfunction

		task check_result(logic signed [RES_W-1:0] t, logic signed [RES_W-1:0] p);
			reading_t want;
			if (pending_readings.size() == 0) begin
				report($sformatf("unexpected word temp=%0d press=%0d", t, p));
				return;
			end
			want = pending_readings.pop_front();
			if (t !== want.temp_centi)
				report($sformatf("temp d1=%0d d2=%0d got %0d want %0d",
					want.d1, want.d2, t, want.temp_centi));
			if (p !== want.pressure)
				report($sformatf("press d1=%0d d2=%0d got %0d want %0d",
					want.d1, want.d2, p, want.pressure));
		endtask

		task flush_leftovers();
			reading_t want;
			while (pending_readings.size() != 0) begin
				want = pending_readings.pop_front();
				report($sformatf("no word for d1=%0d d2=%0d", want.d1, want.d2));
			end
		endtask
	endclass

	bit clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [COEFF_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	logic out_valid;
	logic out_ready;
	logic signed [RES_W-1:0] temperature_centi;
	logic signed [RES_W-1:0] pressure_value;

	compensation_checker sb;
	int in_calm_left = 0;
	int out_calm_left = 0;

	pressure_temperature_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_pressure(raw_pressure),
		.raw_temperature(raw_temperature),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature_centi(temperature_centi),
		.pressure_value(pressure_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Pause length for one word; now and then a stretch with no pauses at all
	function automatic int draw_pause(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm_left = $urandom_range(10, 60);
		return $urandom_range(0, 11);
	endfunction

	// Raw temperature code for a target TEMP under the directed coefficients
	function automatic logic [RAW_W-1:0] temp_code(int t);
		longint v;
		v = 64'sd8388608 + longint'(t - 2000) * 256;
		return v[RAW_W-1:0];
	endfunction

	// Write one register; leaves the write enable high for the caller to drop
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.store_coeff(idx, val);
		@(negedge clk);
	endtask

	task automatic load_coeffs(input logic [COEFF_W-1:0] vals [NUM_COEFFS]);
		for (int i = 0; i < NUM_COEFFS; i++)
			write_reg(i[IDX_W-1:0], vals[i]);
		write_reg(IDX_SPARE_A, COEFF_W'($urandom));
		write_reg(IDX_SPARE_B, COEFF_W'($urandom));
		cfg_we = 1'b0;
	endtask

	// Offer one word and hold it until taken; scramble the payload while idle
	task automatic send_word(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		int gap;
		gap = draw_pause(in_calm_left);
		if (gap > 0) begin
			in_valid = 1'b0;
			raw_pressure = RAW_W'($urandom);
			raw_temperature = RAW_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		raw_pressure = d1;
		raw_temperature = d2;
		do @(posedge clk); while (!in_ready);
		sb.note_word(d1, d2);
		@(negedge clk);
	endtask

	// Accept result words with random stalls and two long hold-offs
	task automatic take_words();
		int stall;
		int taken;
		taken = 0;
		forever begin
			@(negedge clk);
			if (taken == HOLD_POINT_A || taken == HOLD_POINT_B)
				stall = LONG_HOLD;
			else
				stall = draw_pause(out_calm_left);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(temperature_centi, pressure_value);
			taken++;
		end
	endtask

	// Stop offering, wait for every expected word, then let the pipe settle
	task automatic drain();
		int waited;
		waited = 0;
		in_valid = 1'b0;
		while (sb.pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (PIPE_DEPTH + 2) @(negedge clk);
		sb.flush_leftovers();
	endtask

	// Branch boundaries, D1/D2 extremes
	task automatic run_directed();
		logic [RAW_W-1:0] d1;
		foreach (DIRECTED_TEMPS[i]) begin
			case (i % 3)
				0: d1 = '0;
				1: d1 = RAW_MAX;
				default: d1 = RAW_W'($urandom);
			endcase
			send_word(d1, temp_code(DIRECTED_TEMPS[i]));
		end
		send_word('0, '0);
		send_word(RAW_MAX, RAW_MAX);
		send_word('0, RAW_MAX);
		send_word(RAW_MAX, '0);
	endtask

	// Random words; most temperatures land near the reference point
	task automatic run_random(input int count);
		logic [RAW_W-1:0] d1, d2;
		longint near;
		repeat (count) begin
			case ($urandom_range(0, 7))
				0: d1 = '0;
				1: d1 = RAW_MAX;
				default: d1 = RAW_W'($urandom);
			endcase
			if ($urandom_range(0, 2) == 0) begin
				d2 = RAW_W'($urandom);
			end else begin
				near = longint'(sb.coeff[REG_REF_TEMP]) * 256
					+ longint'($urandom_range(0, 2097152)) - 1048576;
				if (near < 0)
					near = 0;
				if (near > longint'(RAW_MAX))
					near = longint'(RAW_MAX);
				d2 = near[RAW_W-1:0];
			end
			send_word(d1, d2);
		end
	endtask

	initial begin
		logic [COEFF_W-1:0] vals [NUM_COEFFS];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		raw_pressure = '0;
		raw_temperature = '0;
		out_ready = 1'b0;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		fork
			take_words();
		join_none

		// coefficients as left by reset
		run_random(40);
		drain();

		vals = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd32768, 16'd32768};
		load_coeffs(vals);
		run_directed();
		drain();

		// typical calibration
		vals = '{16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
		load_coeffs(vals);
		run_random(400);
		drain();

		vals = '{default: '1};
		load_coeffs(vals);
		run_random(250);
		drain();

		vals = '{default: '0};
		load_coeffs(vals);
		run_random(120);
		drain();

		vals = '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
		load_coeffs(vals);
		run_random(100);
		drain();

		repeat (4) begin
			foreach (vals[i]) vals[i] = COEFF_W'($urandom_range(0, 65535));
			load_coeffs(vals);
			run_random(220);
			drain();
		end

		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#(WATCHDOG_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ptc_pkg.sv
hw/rtl/pressure_temperature_compensation.sv
dv/pressure_temperature_compensation_tb.sv
